>>> rtl/core/fvn_pkg.sv
// fvn_pkg: shared types, constants and the cosine weight rom for the fractal value noise unit
// microcode control word layout and the microprogram itself live here
// no dependencies
package fvn_pkg;

  // default configuration of the unit
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int MAX_OCTAVES_DEF = 8;
  localparam int FRAC_BITS_DEF   = 8;

  // fixed field widths
  localparam int POS_W    = 24;
  localparam int TIDX_W   = 12;
  localparam int VAL_W    = 16;
  localparam int OCT_CFG_W = 4;
  localparam int STEP_W   = 16;
  localparam int PERS_W   = 16;
  localparam int GAIN_W   = 18;
  localparam int AMP_W    = 17;
  localparam int MUL_W    = 19;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ROM_SIZE = 256;

  // apb register map
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam logic [1:0] REG_OCTAVES     = 2'd0;
  localparam logic [1:0] REG_STEP        = 2'd1;
  localparam logic [1:0] REG_PERSISTENCE = 2'd2;
  localparam logic [1:0] REG_GAIN        = 2'd3;

  // register reset values
  localparam logic [OCT_CFG_W-1:0] OCTAVES_RST     = 4'd1;
  localparam logic [STEP_W-1:0]    STEP_RST        = 16'd10;
  localparam logic [PERS_W-1:0]    PERSISTENCE_RST = 16'd32768;
  localparam logic [GAIN_W-1:0]    GAIN_RST        = 18'd65536;

  // input operation codes
  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // microprogram addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_E_INIT = 4'd0;
  localparam logic [UPC_W-1:0] UPC_E_DIV  = 4'd1;
  localparam logic [UPC_W-1:0] UPC_E_RD   = 4'd2;
  localparam logic [UPC_W-1:0] UPC_E_MBL  = 4'd3;
  localparam logic [UPC_W-1:0] UPC_E_BLD  = 4'd4;
  localparam logic [UPC_W-1:0] UPC_E_MVA  = 4'd5;
  localparam logic [UPC_W-1:0] UPC_E_ACC  = 4'd6;
  localparam logic [UPC_W-1:0] UPC_E_F0   = 4'd7;
  localparam logic [UPC_W-1:0] UPC_E_F1   = 4'd8;
  localparam logic [UPC_W-1:0] UPC_E_F2   = 4'd9;
  localparam logic [UPC_W-1:0] UPC_E_OUT  = 4'd10;
  localparam logic [UPC_W-1:0] UPC_L_INIT = 4'd11;
  localparam logic [UPC_W-1:0] UPC_L_IDX  = 4'd12;
  localparam logic [UPC_W-1:0] UPC_L_WR   = 4'd13;

  typedef enum logic [2:0] {
    C_NEXT,
    C_LOOP_CNT,
    C_LOOP_OCT,
    C_SKIP_OCTZ,
    C_DONE
  } cond_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_LD_DIV,
    CNT_LD_IDX,
    CNT_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    OCT_HOLD,
    OCT_LOAD,
    OCT_DEC
  } oct_op_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_BLEND,
    MUL_AMP_P,
    MUL_V_AMP,
    MUL_SUM_LO,
    MUL_SUM_HI
  } mul_sel_e;

  // datapath controls carried from sequencer to datapath
  typedef struct packed {
    logic     init;
    logic     div_en;
    logic     idx_ld_en;
    logic     mem_rd;
    logic     mem_wr;
    logic     w_en;
    mul_sel_e mul_sel;
    logic     blend_en;
    logic     amp_en;
    logic     sum_en;
    logic     fin_ld;
    logic     fin_acc;
  } dp_ctl_t;

  // one microinstruction
  typedef struct packed {
    cond_e            cond;
    logic [UPC_W-1:0] target;
    cnt_op_e          cnt_op;
    oct_op_e          oct_op;
    logic             out_en;
    dp_ctl_t          ctl;
  } ucw_t;

  localparam dp_ctl_t CTL_NOP = '{
    init: 1'b0, div_en: 1'b0, idx_ld_en: 1'b0, mem_rd: 1'b0, mem_wr: 1'b0,
    w_en: 1'b0, mul_sel: MUL_NONE, blend_en: 1'b0, amp_en: 1'b0,
    sum_en: 1'b0, fin_ld: 1'b0, fin_acc: 1'b0
  };

  // microprogram rom
  function automatic ucw_t ucode(input logic [UPC_W-1:0] upc);
    ucw_t cw;
    cw = '{cond: C_NEXT, target: UPC_E_INIT, cnt_op: CNT_HOLD, oct_op: OCT_HOLD,
           out_en: 1'b0, ctl: CTL_NOP};
    unique case (upc)
      UPC_E_INIT: begin
        cw.ctl.init = 1'b1;
        cw.cnt_op   = CNT_LD_DIV;
        cw.oct_op   = OCT_LOAD;
        cw.cond     = C_SKIP_OCTZ;
        cw.target   = UPC_E_F0;
      end
      UPC_E_DIV: begin
        cw.ctl.div_en = 1'b1;
        cw.cnt_op     = CNT_DEC;
        cw.cond       = C_LOOP_CNT;
        cw.target     = UPC_E_DIV;
      end
      UPC_E_RD: begin
        cw.ctl.mem_rd = 1'b1;
        cw.ctl.w_en   = 1'b1;
      end
      UPC_E_MBL: begin
        cw.ctl.mul_sel = MUL_BLEND;
      end
      UPC_E_BLD: begin
        cw.ctl.blend_en = 1'b1;
        cw.ctl.mul_sel  = MUL_AMP_P;
      end
      UPC_E_MVA: begin
        cw.ctl.mul_sel = MUL_V_AMP;
        cw.ctl.amp_en  = 1'b1;
      end
      UPC_E_ACC: begin
        cw.ctl.sum_en = 1'b1;
        cw.ctl.div_en = 1'b1;
        cw.oct_op     = OCT_DEC;
        cw.cond       = C_LOOP_OCT;
        cw.target     = UPC_E_RD;
      end
      UPC_E_F0: begin
        cw.ctl.mul_sel = MUL_SUM_LO;
      end
      UPC_E_F1: begin
        cw.ctl.fin_ld  = 1'b1;
        cw.ctl.mul_sel = MUL_SUM_HI;
      end
      UPC_E_F2: begin
        cw.ctl.fin_acc = 1'b1;
      end
      UPC_E_OUT: begin
        cw.out_en = 1'b1;
        cw.cond   = C_DONE;
      end
      UPC_L_INIT: begin
        cw.ctl.init = 1'b1;
        cw.cnt_op   = CNT_LD_IDX;
      end
      UPC_L_IDX: begin
        cw.ctl.idx_ld_en = 1'b1;
        cw.cnt_op        = CNT_DEC;
        cw.cond          = C_LOOP_CNT;
        cw.target        = UPC_L_IDX;
      end
      UPC_L_WR: begin
        cw.ctl.mem_wr = 1'b1;
        cw.cond       = C_DONE;
      end
      default: begin
        cw.cond = C_DONE;
      end
    endcase
    return cw;
  endfunction

  // cosine weight rom, (1 - cos(pi*n/256))/2 in q0.16
  localparam logic [63:0] PI_OVER_512_Q32 = 64'd26353589;

  typedef logic [VAL_W-1:0] rom_t [ROM_SIZE];

  // sin^2(pi*n/512) via a q32 taylor series
  function automatic logic [VAL_W-1:0] half_weight(input logic [8:0] n);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    x    = 64'(n) * PI_OVER_512_Q32;
    x2   = (x * x) >> 32;
    term = x;
    s    = x;
    term = ((term * x2) >> 32) / 64'd6;
    s    = s - term;
    term = ((term * x2) >> 32) / 64'd20;
    s    = s + term;
    term = ((term * x2) >> 32) / 64'd42;
    s    = s - term;
    term = ((term * x2) >> 32) / 64'd72;
    s    = s + term;
    term = ((term * x2) >> 32) / 64'd110;
    s    = s - term;
    term = ((term * x2) >> 32) / 64'd156;
    s    = s + term;
    return VAL_W'((((s * s) >> 32) + 64'd32768) >> 16);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int n = 0; n < ROM_SIZE; n++) begin
      if (n <= 128) begin
        r[n] = half_weight(9'(n));
      end else begin
        r[n] = VAL_W'(17'd65536 - 17'(half_weight(9'(ROM_SIZE - n))));
      end
    end
    return r;
  endfunction

  localparam rom_t COS_ROM = build_rom();

endpackage

>>> rtl/core/fractal_value_noise_1d_unit.sv
// fractal_value_noise_1d_unit: 1d fractal value noise with cosine blending, microcoded
// evaluate: the bit-serial division, then the 5-step octave loop once per octave, then the final scaling;
//   the division and the octave loop are skipped when octave_count is zero
// load: a serial reduction of the table index, then the write; one transaction at a time,
//   the next accepted the cycle after the previous one finishes, while a result may still wait
// reset: async active low, registers back to defaults, lattice table undefined until written
module fractal_value_noise_1d_unit #(
  parameter int TABLE_DEPTH = fvn_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [fvn_pkg::POS_W-1:0]    position_i,
  input  logic [fvn_pkg::TIDX_W-1:0]   table_index_i,
  input  logic [fvn_pkg::VAL_W-1:0]    table_value_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fvn_pkg::VAL_W-1:0]    noise_value_o,
  // apb configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fvn_pkg::APB_AW-1:0]   paddr,
  input  logic [fvn_pkg::APB_DW-1:0]   pwdata,
  output logic [fvn_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import fvn_pkg::*;

  logic [OCT_CFG_W-1:0] octave_count_q;
  logic [STEP_W-1:0]    lattice_step_q;
  logic [PERS_W-1:0]    persistence_q;
  logic [GAIN_W-1:0]    norm_gain_q;
  logic                 out_valid_q;
  logic [VAL_W-1:0]     noise_value_q;

  logic                 cfg_wr;
  logic                 in_accept;
  logic                 busy;
  logic                 out_fire;
  logic                 out_free;
  logic [VAL_W-1:0]     result;
  dp_ctl_t              ctl;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_count_q <= OCTAVES_RST;
      lattice_step_q <= STEP_RST;
      persistence_q  <= PERSISTENCE_RST;
      norm_gain_q    <= GAIN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_OCTAVES:     octave_count_q <= pwdata[OCT_CFG_W-1:0];
        REG_STEP:        lattice_step_q <= pwdata[STEP_W-1:0];
        REG_PERSISTENCE: persistence_q  <= pwdata[PERS_W-1:0];
        REG_GAIN:        norm_gain_q    <= pwdata[GAIN_W-1:0];
        default:         octave_count_q <= octave_count_q;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_OCTAVES:     prdata = APB_DW'(octave_count_q);
      REG_STEP:        prdata = APB_DW'(lattice_step_q);
      REG_PERSISTENCE: prdata = APB_DW'(persistence_q);
      REG_GAIN:        prdata = APB_DW'(norm_gain_q);
      default:         prdata = '0;
    endcase
  end

  // input transaction handshake
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;

  fvn_useq #(
    .MAX_OCTAVES (MAX_OCTAVES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_useq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (in_accept),
    .op_i           (op_i),
    .octave_count_i (octave_count_q),
    .out_free_i     (out_free),
    .busy_o         (busy),
    .out_fire_o     (out_fire),
    .ctl_o          (ctl)
  );

  fvn_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_OCTAVES (MAX_OCTAVES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .load_i         (in_accept),
    .op_i           (op_i),
    .position_i     (position_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .lattice_step_i (lattice_step_q),
    .persistence_i  (persistence_q),
    .norm_gain_i    (norm_gain_q),
    .ctl_i          (ctl),
    .result_o       (result)
  );

  // result register, freed in the same cycle it is taken
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      noise_value_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_value_q;

  // an accepted transaction always occupies the sequencer next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> busy)
    else $error("accepted transaction did not start the sequencer");

  // a new result only appears from the sequencer output step
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(out_fire))
    else $error("result valid without output step");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

endmodule

>>> rtl/core/fvn_lattice_ram.sv
// fvn_lattice_ram: lattice value store, one write port and two registered read ports
// depends on fvn_pkg for the value width
module fvn_lattice_ram #(
  parameter int DEPTH = fvn_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [fvn_pkg::VAL_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_a_i,
  input  logic [AW-1:0]            raddr_b_i,
  output logic [fvn_pkg::VAL_W-1:0] rdata_a_o,
  output logic [fvn_pkg::VAL_W-1:0] rdata_b_o
);
  import fvn_pkg::*;

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rd_a_q;
  logic [VAL_W-1:0] rd_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads of both neighbours
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_a_q <= mem_q[raddr_a_i];
      rd_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

>>> rtl/core/fvn_useq.sv
// fvn_useq: microcode sequencer, program counter, loop and octave counters
// depends on fvn_pkg for the microprogram and control word types
module fvn_useq #(
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         op_i,
  input  logic [fvn_pkg::OCT_CFG_W-1:0] octave_count_i,
  input  logic                         out_free_i,
  output logic                         busy_o,
  output logic                         out_fire_o,
  output fvn_pkg::dp_ctl_t             ctl_o
);
  import fvn_pkg::*;

  localparam int DIV_STEPS = 16 + FRAC_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int OCT_W     = $clog2(MAX_OCTAVES + 1);

  logic             busy_q, busy_d;
  logic [UPC_W-1:0] pc_q, pc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [OCT_W-1:0] oct_q, oct_d;
  ucw_t             cw;
  logic             adv;
  logic [4:0]       oct_eff;

  // octave count clipped to the supported maximum
  assign oct_eff = (5'(octave_count_i) > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
                                                          : 5'(octave_count_i);

  assign cw  = ucode(pc_q);
  // hold at the output step while the result register is still occupied
  assign adv = busy_q && !(cw.out_en && !out_free_i);

  // next pc, counters and busy flag
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    cnt_d  = cnt_q;
    oct_d  = oct_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = (op_i == OP_LOAD) ? UPC_L_INIT : UPC_E_INIT;
      end
    end else if (adv) begin
      unique case (cw.cnt_op)
        CNT_HOLD:   cnt_d = cnt_q;
        CNT_LD_DIV: cnt_d = CNT_W'(DIV_STEPS - 1);
        CNT_LD_IDX: cnt_d = CNT_W'(TIDX_W - 1);
        CNT_DEC:    cnt_d = cnt_q - CNT_W'(1);
        default:    cnt_d = cnt_q;
      endcase
      unique case (cw.oct_op)
        OCT_HOLD: oct_d = oct_q;
        OCT_LOAD: oct_d = OCT_W'(oct_eff - 5'd1);
        OCT_DEC:  oct_d = oct_q - OCT_W'(1);
        default:  oct_d = oct_q;
      endcase
      unique case (cw.cond)
        C_NEXT:      pc_d = pc_q + UPC_W'(1);
        C_LOOP_CNT:  pc_d = (cnt_q != '0) ? cw.target : pc_q + UPC_W'(1);
        C_LOOP_OCT:  pc_d = (oct_q != '0) ? cw.target : pc_q + UPC_W'(1);
        C_SKIP_OCTZ: pc_d = (oct_eff == 5'd0) ? cw.target : pc_q + UPC_W'(1);
        C_DONE:      busy_d = 1'b0;
        default:     busy_d = 1'b0;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= UPC_E_INIT;
      cnt_q  <= '0;
      oct_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      cnt_q  <= cnt_d;
      oct_q  <= oct_d;
    end
  end

  assign busy_o     = busy_q;
  assign out_fire_o = adv && cw.out_en;
  assign ctl_o      = adv ? cw.ctl : CTL_NOP;

  // program counter never runs past the end of the load program
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q <= UPC_L_WR)
    else $error("sequencer pc outside program");

  // every transaction starts at the head of a program
  a_start_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && start_i) |=> (busy_q && (pc_q == UPC_E_INIT || pc_q == UPC_L_INIT)))
    else $error("sequencer started off a program entry");

  // a load never reaches the result step
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && pc_q == UPC_L_IDX) |=> (pc_q == UPC_L_IDX || pc_q == UPC_L_WR))
    else $error("load program left its loop");

endmodule

>>> rtl/core/fvn_dpath.sv
// fvn_dpath: bit-serial divider, index reducer, cosine rom, shared multiplier and accumulators
// depends on fvn_pkg and fvn_lattice_ram
module fvn_dpath #(
  parameter int TABLE_DEPTH = fvn_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic                          op_i,
  input  logic [fvn_pkg::POS_W-1:0]     position_i,
  input  logic [fvn_pkg::TIDX_W-1:0]    table_index_i,
  input  logic [fvn_pkg::VAL_W-1:0]     table_value_i,
  input  logic [fvn_pkg::STEP_W-1:0]    lattice_step_i,
  input  logic [fvn_pkg::PERS_W-1:0]    persistence_i,
  input  logic [fvn_pkg::GAIN_W-1:0]    norm_gain_i,
  input  fvn_pkg::dp_ctl_t              ctl_i,
  output logic [fvn_pkg::VAL_W-1:0]     result_o
);
  import fvn_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int FB    = FRAC_BITS;
  localparam int SUM_W = 32 + $clog2(MAX_OCTAVES);
  localparam int HI_W  = SUM_W - 18;
  localparam int FIN_W = SUM_W + 18;
  localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  logic [POS_W-1:0]         pos_q;
  logic [VAL_W-1:0]         val_q;
  logic [STEP_W-1:0]        rem_q;
  logic [FB-1:0]            frac_q;
  logic [AW-1:0]            idx_q;
  logic [VAL_W-1:0]         w_q;
  logic [VAL_W-1:0]         v_q;
  logic [AMP_W-1:0]         amp_q;
  logic [SUM_W-1:0]         sum_q;
  logic [FIN_W-1:0]         fin_q;
  logic signed [PROD_W-1:0] prod_q;

  logic [STEP_W-1:0]        step_eff;
  logic [STEP_W:0]          rem_x;
  logic                     quo_bit;
  logic                     idx_bit;
  logic [AW:0]              idx_x;
  logic [AW:0]              idx_red;
  logic [AW-1:0]            idx_nb;
  logic [FB+7:0]            frac_ext;
  logic [VAL_W-1:0]         rd_a;
  logic [VAL_W-1:0]         rd_b;
  logic signed [VAL_W:0]    diff;
  logic signed [MUL_W-1:0]  opa;
  logic signed [MUL_W-1:0]  opb;
  logic signed [33:0]       blend;
  logic [FIN_W:0]           rnd;
  logic [FIN_W-32:0]        quo;

  // restoring division step, one quotient bit per cycle
  assign step_eff = (lattice_step_i == '0) ? STEP_W'(1) : lattice_step_i;
  assign rem_x    = {rem_q, pos_q[POS_W-1]};
  assign quo_bit  = rem_x >= {1'b0, step_eff};

  // integer part kept modulo the table depth, one bit shifted in per step
  assign idx_bit = ctl_i.div_en ? frac_q[FB-1] : pos_q[POS_W-1];
  assign idx_x   = {idx_q, idx_bit};
  assign idx_red = (idx_x >= DEPTH_X) ? idx_x - DEPTH_X : idx_x;
  assign idx_nb  = (idx_q == LAST_IDX) ? '0 : idx_q + AW'(1);

  // rom index is the fraction rescaled to eight bits
  assign frac_ext = {frac_q, 8'h00};

  // operand selection for the shared multiplier
  assign diff = $signed({1'b0, rd_b}) - $signed({1'b0, rd_a});
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (ctl_i.mul_sel)
      MUL_NONE: begin
        opa = '0;
        opb = '0;
      end
      MUL_BLEND: begin
        opa = {{(MUL_W - VAL_W - 1){diff[VAL_W]}}, diff};
        opb = {{(MUL_W - VAL_W){1'b0}}, w_q};
      end
      MUL_AMP_P: begin
        opa = {{(MUL_W - AMP_W){1'b0}}, amp_q};
        opb = {{(MUL_W - PERS_W){1'b0}}, persistence_i};
      end
      MUL_V_AMP: begin
        opa = {{(MUL_W - VAL_W){1'b0}}, v_q};
        opb = {{(MUL_W - AMP_W){1'b0}}, amp_q};
      end
      MUL_SUM_LO: begin
        opa = {1'b0, sum_q[17:0]};
        opb = {{(MUL_W - GAIN_W){1'b0}}, norm_gain_i};
      end
      MUL_SUM_HI: begin
        opa = {{(MUL_W - HI_W){1'b0}}, sum_q[SUM_W-1:18]};
        opb = {{(MUL_W - GAIN_W){1'b0}}, norm_gain_i};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // cosine blend, rounded back to q0.16
  assign blend = $signed({2'b00, rd_a, 16'h0000}) + $signed(prod_q[33:0]) + 34'sd32768;

  // final scaling, rounding and saturation
  assign rnd      = {1'b0, fin_q} + (FIN_W + 1)'(64'h8000_0000);
  assign quo      = rnd[FIN_W:32];
  assign result_o = (|quo[FIN_W-32:16]) ? {VAL_W{1'b1}} : quo[15:0];

  // operand capture at transaction acceptance
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pos_q <= (op_i == OP_LOAD) ? {table_index_i, {(POS_W - TIDX_W){1'b0}}} : position_i;
      val_q <= table_value_i;
    end else if (ctl_i.div_en || ctl_i.idx_ld_en) begin
      pos_q <= {pos_q[POS_W-2:0], 1'b0};
    end
  end

  // quotient, remainder and index registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      rem_q  <= '0;
      frac_q <= '0;
      idx_q  <= '0;
    end else begin
      if (ctl_i.div_en) begin
        rem_q  <= quo_bit ? STEP_W'(rem_x - {1'b0, step_eff}) : rem_x[STEP_W-1:0];
        frac_q <= {frac_q[FB-2:0], quo_bit};
      end
      if (ctl_i.div_en || ctl_i.idx_ld_en) begin
        idx_q <= idx_red[AW-1:0];
      end
    end
  end

  // weight, blend, amplitude and sums
  always_ff @(posedge clk_i) begin
    if (ctl_i.w_en) begin
      w_q <= COS_ROM[frac_ext[FB+7:FB]];
    end
    if (ctl_i.blend_en) begin
      v_q <= blend[31:16];
    end
    if (ctl_i.init) begin
      amp_q <= AMP_W'(17'h10000);
      sum_q <= '0;
    end else begin
      if (ctl_i.amp_en) begin
        amp_q <= prod_q[32:16];
      end
      if (ctl_i.sum_en) begin
        sum_q <= sum_q + SUM_W'(prod_q[31:0]);
      end
    end
    if (ctl_i.fin_ld) begin
      fin_q <= FIN_W'(prod_q[35:0]);
    end else if (ctl_i.fin_acc) begin
      fin_q <= fin_q + {prod_q[HI_W+17:0], 18'h00000};
    end
    prod_q <= opa * opb;
  end

  fvn_lattice_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ctl_i.mem_wr),
    .waddr_i   (idx_q),
    .wdata_i   (val_q),
    .re_i      (ctl_i.mem_rd),
    .raddr_a_i (idx_q),
    .raddr_b_i (idx_nb),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

endmodule
